// ----- rtl/set_assoc_lru_cache_tags_top_macros.svh -----
// Assertion macros for the set-associative LRU cache tag block.
`ifndef SET_ASSOC_LRU_CACHE_TAGS_TOP_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SALC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("salc assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define SALC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("salc assertion failed");

`endif

// ----- rtl/salc_pkg.sv -----
// Shared types and constants for the set-associative LRU cache tag block.
package salc_pkg;

   localparam int MAX_WAYS   = 8;
   localparam int MAX_SETS   = 1024;
   localparam int ADDR_W     = 32;
   localparam int TAG_W      = 32;
   localparam int WAY_W      = $clog2(MAX_WAYS);
   localparam int WAYS_CNT_W = $clog2(MAX_WAYS + 1);
   localparam int SET_W      = $clog2(MAX_SETS);
   localparam int RANK_W     = 3;
   localparam int COUNT_W    = 32;

   localparam int WAYS_CFG_W   = 4;
   localparam int OFFSET_CFG_W = 5;
   localparam int INDEX_CFG_W  = 4;
   localparam int SHIFT_W      = 6;

   localparam logic [RANK_W-1:0]       RANK_MAX      = 3'd7;
   localparam logic [WAYS_CFG_W-1:0]   WAYS_RESET    = 4'd1;
   localparam logic [OFFSET_CFG_W-1:0] OFFSET_RESET  = 5'd4;
   localparam logic [INDEX_CFG_W-1:0]  INDEX_RESET   = 4'd6;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX  = 2'd2;

   typedef struct packed {
      logic [WAYS_CNT_W-1:0] ways;
   } cfg_type;

   typedef struct packed {
      logic [SET_W-1:0] set_idx;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
      logic [MAX_WAYS-1:0]             valid;
   } meta_type;

   typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_type;

   typedef struct packed {
      logic clearing;
   } back_stat_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RESOLVE
   } back_state_type;

endpackage

// ----- rtl/salc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module salc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/salc_queue.sv -----
// Short FIFO of classified lookups between the front and back ends.
module salc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  salc_pkg::entry_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output salc_pkg::entry_type  head
);

   salc_pkg::entry_type                slot_ff [salc_pkg::QUEUE_DEPTH];
   logic [salc_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [salc_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [salc_pkg::QCNT_W-1:0]        count_ff, count_in;

   assign full      = (count_ff == salc_pkg::QCNT_W'(salc_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == salc_pkg::QPTR_W'(salc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == salc_pkg::QPTR_W'(salc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/salc_front.sv -----
// Front end: configuration registers, request acceptance and address split.
module salc_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [salc_pkg::ADDR_W-1:0]             req_address,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [salc_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [salc_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [salc_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                    pready,
   input  salc_pkg::back_stat_type                 stat,
   input  logic                                    queue_full,
   output logic                                    push,
   output salc_pkg::entry_type                     push_data,
   output salc_pkg::cfg_type                       cfg
);

   logic [salc_pkg::WAYS_CFG_W-1:0]   ways_ff, ways_in;
   logic [salc_pkg::OFFSET_CFG_W-1:0] offset_ff, offset_in;
   logic [salc_pkg::INDEX_CFG_W-1:0]  index_ff, index_in;
   logic [salc_pkg::CSR_IDX_W-1:0]    reg_idx;
   logic                              csr_write;
   logic [salc_pkg::INDEX_CFG_W-1:0]  ib_eff;
   logic [salc_pkg::ADDR_W-1:0]       set_mask;
   logic [salc_pkg::ADDR_W-1:0]       set_full;
   logic [salc_pkg::SHIFT_W-1:0]      tag_shift;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[salc_pkg::CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      ways_in   = ways_ff;
      offset_in = offset_ff;
      index_in  = index_ff;
      if (csr_write) begin
         case (reg_idx)
            salc_pkg::CSR_WAYS:   ways_in   = pwdata[salc_pkg::WAYS_CFG_W-1:0];
            salc_pkg::CSR_OFFSET: offset_in = pwdata[salc_pkg::OFFSET_CFG_W-1:0];
            salc_pkg::CSR_INDEX:  index_in  = pwdata[salc_pkg::INDEX_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         salc_pkg::CSR_WAYS:   prdata = salc_pkg::CSR_DATA_W'(ways_ff);
         salc_pkg::CSR_OFFSET: prdata = salc_pkg::CSR_DATA_W'(offset_ff);
         salc_pkg::CSR_INDEX:  prdata = salc_pkg::CSR_DATA_W'(index_ff);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff   <= salc_pkg::WAYS_RESET;
         offset_ff <= salc_pkg::OFFSET_RESET;
         index_ff  <= salc_pkg::INDEX_RESET;
      end else begin
         ways_ff   <= ways_in;
         offset_ff <= offset_in;
         index_ff  <= index_in;
      end
   end

   // effective associativity and index width
   always_comb begin
      if (ways_ff == '0) begin
         cfg.ways = salc_pkg::WAYS_CNT_W'(1);
      end else if (ways_ff > salc_pkg::WAYS_CFG_W'(salc_pkg::MAX_WAYS)) begin
         cfg.ways = salc_pkg::WAYS_CNT_W'(salc_pkg::MAX_WAYS);
      end else begin
         cfg.ways = salc_pkg::WAYS_CNT_W'(ways_ff);
      end
      if (index_ff > salc_pkg::INDEX_CFG_W'(salc_pkg::SET_W)) begin
         ib_eff = salc_pkg::INDEX_CFG_W'(salc_pkg::SET_W);
      end else begin
         ib_eff = index_ff;
      end
   end

   assign set_mask  = (salc_pkg::ADDR_W'(1) << ib_eff) - salc_pkg::ADDR_W'(1);
   assign set_full  = (req_address >> offset_ff) & set_mask;
   assign tag_shift = salc_pkg::SHIFT_W'(offset_ff) + salc_pkg::SHIFT_W'(ib_eff);

   assign push_data.set_idx = set_full[salc_pkg::SET_W-1:0];
   assign push_data.tag     = salc_pkg::TAG_W'(req_address >> tag_shift);

   assign req_ready = !queue_full && !stat.clearing;
   assign push      = req_valid && req_ready;

endmodule

// ----- rtl/salc_back.sv -----
// Back end: set read, tag compare, LRU update, write-back and result register.
module salc_back (
   input  logic                               clock,
   input  logic                               reset,
   input  salc_pkg::cfg_type                  cfg,
   input  logic                               q_valid,
   input  salc_pkg::entry_type                q_head,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_hit,
   output logic [salc_pkg::WAY_W-1:0]         rsp_way_used,
   output logic [salc_pkg::COUNT_W-1:0]       rsp_hit_count,
   output logic [salc_pkg::COUNT_W-1:0]       rsp_access_count,
   output salc_pkg::back_stat_type            stat
);

   salc_pkg::back_state_type         state_ff, state_in;
   salc_pkg::entry_type              cur_ff, cur_in;
   logic [salc_pkg::SET_W-1:0]       clr_ff, clr_in;
   logic [salc_pkg::COUNT_W-1:0]     hits_ff, hits_in;
   logic [salc_pkg::COUNT_W-1:0]     acc_ff, acc_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_hit_ff, rsp_hit_in;
   logic [salc_pkg::WAY_W-1:0]       rsp_way_ff, rsp_way_in;

   logic                             issue;
   logic                             meta_wr_en;
   logic [salc_pkg::SET_W-1:0]       meta_wr_addr;
   salc_pkg::meta_type               meta_wr_data;
   salc_pkg::meta_type               meta_rd;
   logic                             tag_wr_en;
   salc_pkg::tag_row_type            tags_rd;
   salc_pkg::tag_row_type            tags_new;
   salc_pkg::meta_type               meta_new;

   logic [salc_pkg::MAX_WAYS-1:0]    in_use;
   logic [salc_pkg::MAX_WAYS-1:0]    match;
   logic [salc_pkg::MAX_WAYS-1:0]    free;
   logic                             hit;
   logic                             found_free;
   logic [salc_pkg::WAY_W-1:0]       hit_way;
   logic [salc_pkg::WAY_W-1:0]       free_way;
   logic [salc_pkg::WAY_W-1:0]       victim;
   logic [salc_pkg::WAY_W-1:0]       way;
   logic [salc_pkg::RANK_W:0]        old_rank;

   salc_ram #(
      .WIDTH ($bits(salc_pkg::meta_type)),
      .DEPTH (salc_pkg::MAX_SETS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wr_data),
      .rd_en   (issue),
      .rd_addr (q_head.set_idx),
      .rd_data (meta_rd)
   );

   salc_ram #(
      .WIDTH ($bits(salc_pkg::tag_row_type)),
      .DEPTH (salc_pkg::MAX_SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (cur_ff.set_idx),
      .wr_data (tags_new),
      .rd_en   (issue),
      .rd_addr (q_head.set_idx),
      .rd_data (tags_rd)
   );

   // compare, victim selection and rank update on the row read for cur_ff
   always_comb begin
      for (int w = 0; w < salc_pkg::MAX_WAYS; w++) begin
         in_use[w] = salc_pkg::WAYS_CNT_W'(w) < cfg.ways;
         match[w]  = in_use[w] && meta_rd.valid[w] && (tags_rd[w] == cur_ff.tag);
         free[w]   = in_use[w] && !meta_rd.valid[w];
      end
      hit        = |match;
      found_free = |free;
      hit_way    = '0;
      free_way   = '0;
      for (int w = salc_pkg::MAX_WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way = salc_pkg::WAY_W'(w);
         end
         if (free[w]) begin
            free_way = salc_pkg::WAY_W'(w);
         end
      end
      victim = '0;
      for (int w = 1; w < salc_pkg::MAX_WAYS; w++) begin
         if (in_use[w] && (meta_rd.rank[w] > meta_rd.rank[victim])) begin
            victim = salc_pkg::WAY_W'(w);
         end
      end
      if (hit) begin
         way      = hit_way;
         old_rank = {1'b0, meta_rd.rank[hit_way]};
      end else if (found_free) begin
         way      = free_way;
         old_rank = {1'b0, salc_pkg::RANK_MAX} + 1'b1;
      end else begin
         way      = victim;
         old_rank = {1'b0, meta_rd.rank[victim]};
      end
      meta_new = meta_rd;
      for (int w = 0; w < salc_pkg::MAX_WAYS; w++) begin
         if (in_use[w] && meta_rd.valid[w] && (salc_pkg::WAY_W'(w) != way) &&
             ({1'b0, meta_rd.rank[w]} < old_rank) &&
             (meta_rd.rank[w] != salc_pkg::RANK_MAX)) begin
            meta_new.rank[w] = meta_rd.rank[w] + 1'b1;
         end
      end
      meta_new.rank[way]  = '0;
      meta_new.valid[way] = 1'b1;
      tags_new            = tags_rd;
      tags_new[way]       = cur_ff.tag;
   end

   assign issue = (state_ff == salc_pkg::ST_IDLE) && q_valid &&
                  (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      clr_in       = clr_ff;
      hits_in      = hits_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_way_in   = rsp_way_ff;
      q_pop        = 1'b0;
      meta_wr_en   = 1'b0;
      meta_wr_addr = cur_ff.set_idx;
      meta_wr_data = meta_new;
      tag_wr_en    = 1'b0;
      case (state_ff)
         salc_pkg::ST_CLEAR: begin
            meta_wr_en   = 1'b1;
            meta_wr_addr = clr_ff;
            meta_wr_data = '0;
            clr_in       = clr_ff + 1'b1;
            if (clr_ff == salc_pkg::SET_W'(salc_pkg::MAX_SETS - 1)) begin
               state_in = salc_pkg::ST_IDLE;
            end
         end
         salc_pkg::ST_IDLE: begin
            if (issue) begin
               q_pop    = 1'b1;
               cur_in   = q_head;
               state_in = salc_pkg::ST_RESOLVE;
            end
         end
         salc_pkg::ST_RESOLVE: begin
            meta_wr_en   = 1'b1;
            tag_wr_en    = !hit;
            rsp_valid_in = 1'b1;
            rsp_hit_in   = hit;
            rsp_way_in   = way;
            if (hit && (hits_ff != '1)) begin
               hits_in = hits_ff + 1'b1;
            end
            if (acc_ff != '1) begin
               acc_in = acc_ff + 1'b1;
            end
            state_in = salc_pkg::ST_IDLE;
         end
         default: begin
            state_in = salc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= salc_pkg::ST_CLEAR;
         clr_ff       <= '0;
         hits_ff      <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hits_ff      <= hits_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_way_ff <= rsp_way_in;
   end

   assign stat.clearing    = (state_ff == salc_pkg::ST_CLEAR);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_way_used     = rsp_way_ff;
   assign rsp_hit_count    = hits_ff;
   assign rsp_access_count = acc_ff;

endmodule

// ----- rtl/set_assoc_lru_cache_tags_top.sv -----
// Top level of the set-associative LRU cache tag block.
// Path: an accepted request is queued, then issued in ST_IDLE with a registered read of
// the set's row in the tag and state RAMs, resolved in ST_RESOLVE by the read-modify-write
// of that row, and the result is registered; a new transaction issues only after ST_RESOLVE.
// Reset: a clearing pass over all 1024 sets of the valid/rank RAM, req_ready low;
// counters clear and configuration returns to 1 way, 4 offset bits, 6 index bits.
`include "set_assoc_lru_cache_tags_top_macros.svh"

module set_assoc_lru_cache_tags_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [salc_pkg::ADDR_W-1:0]        req_address,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_hit,
   output logic [salc_pkg::WAY_W-1:0]         rsp_way_used,
   output logic [salc_pkg::COUNT_W-1:0]       rsp_hit_count,
   output logic [salc_pkg::COUNT_W-1:0]       rsp_access_count,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [salc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [salc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [salc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);

   salc_pkg::back_stat_type  stat;
   salc_pkg::cfg_type        cfg;
   salc_pkg::entry_type      push_data;
   salc_pkg::entry_type      q_head;
   logic                     push;
   logic                     queue_full;
   logic                     q_valid;
   logic                     q_pop;

   salc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_address (req_address),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .stat        (stat),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data),
      .cfg         (cfg)
   );

   salc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (q_head)
   );

   salc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_valid          (q_valid),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_way_used     (rsp_way_used),
      .rsp_hit_count    (rsp_hit_count),
      .rsp_access_count (rsp_access_count),
      .stat             (stat)
   );

   `SALC_ASSERT_NOW(a_hits_le_accesses, rsp_valid, rsp_hit_count <= rsp_access_count)
   `SALC_ASSERT_NOW(a_hit_counted, rsp_valid && rsp_hit, rsp_hit_count != '0)
   `SALC_ASSERT_NOW(a_no_rsp_in_clear, stat.clearing, !rsp_valid)
   `SALC_ASSERT_NEXT(a_push_lands, push, q_valid)

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the set-associative LRU cache tag block.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import salc_pkg::*;

   localparam int TIMEOUT_NS = 2000000;

   typedef struct {
      bit               hit;
      bit [WAY_W-1:0]   way;
      bit [COUNT_W-1:0] hit_count;
      bit [COUNT_W-1:0] access_count;
   } lookup_result;

   class lru_tag_predictor;
      bit [TAG_W-1:0]   tag_mem   [MAX_SETS*MAX_WAYS];
      bit               valid_mem [MAX_SETS*MAX_WAYS];
      bit [RANK_W-1:0]  rank_mem  [MAX_SETS*MAX_WAYS];
      bit [COUNT_W-1:0] hits;
      bit [COUNT_W-1:0] accesses;
      bit [WAYS_CFG_W-1:0]   ways_cfg   = WAYS_RESET;
      bit [OFFSET_CFG_W-1:0] offset_cfg = OFFSET_RESET;
      bit [INDEX_CFG_W-1:0]  index_cfg  = INDEX_RESET;
      lookup_result pending_lookups [$];
      int errors;

      function int active_ways();
         if (ways_cfg == 0) return 1;
         if (ways_cfg > MAX_WAYS) return MAX_WAYS;
         return int'(ways_cfg);
      endfunction

      function int active_index_bits();
         int ib;
         ib = int'(index_cfg);
         while (ib > 0 && (1 << ib) > MAX_SETS) ib--;
         return ib;
      endfunction

      // returns the value a readback should show
      function bit [CSR_DATA_W-1:0] set_reg(logic [CSR_IDX_W-1:0] idx,
                                            bit [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_WAYS: begin
               ways_cfg = value[WAYS_CFG_W-1:0];
               return CSR_DATA_W'(ways_cfg);
            end
            CSR_OFFSET: begin
               offset_cfg = value[OFFSET_CFG_W-1:0];
               return CSR_DATA_W'(offset_cfg);
            end
            default: begin
               index_cfg = value[INDEX_CFG_W-1:0];
               return CSR_DATA_W'(index_cfg);
            end
         endcase
      endfunction

      function void touch(int base, int nways, int way, int old_rank);
         for (int w = 0; w < nways; w++) begin
            if (w != way && valid_mem[base+w] && rank_mem[base+w] < old_rank &&
                rank_mem[base+w] < RANK_MAX)
               rank_mem[base+w]++;
         end
         rank_mem[base+way] = '0;
      endfunction

      function void note_access(logic [ADDR_W-1:0] addr);
         logic [63:0] a64;
         int nways, ib, base, way, set_idx;
         bit [TAG_W-1:0] tag;
         bit hit, found;
         lookup_result res;
         a64 = {32'd0, addr};
         nways = active_ways();
         ib = active_index_bits();
         set_idx = int'((a64 >> offset_cfg) & ((64'd1 << ib) - 64'd1));
         tag = TAG_W'(a64 >> (int'(offset_cfg) + ib));
         base = set_idx * MAX_WAYS;
         hit = 0;
         way = 0;
         for (int w = 0; w < nways; w++) begin
            if (!hit && valid_mem[base+w] && tag_mem[base+w] == tag) begin
               hit = 1;
               way = w;
            end
         end
         if (hit) begin
            touch(base, nways, way, int'(rank_mem[base+way]));
            if (hits != '1) hits++;
         end else begin
            found = 0;
            for (int w = 0; w < nways; w++) begin
               if (!found && !valid_mem[base+w]) begin
                  found = 1;
                  way = w;
               end
            end
            if (found) begin
               touch(base, nways, way, int'(RANK_MAX) + 1);
            end else begin
               way = 0;
               for (int w = 1; w < nways; w++)
                  if (rank_mem[base+w] > rank_mem[base+way]) way = w;
               touch(base, nways, way, int'(rank_mem[base+way]));
            end
            tag_mem[base+way] = tag;
            valid_mem[base+way] = 1;
         end
         if (accesses != '1) accesses++;
         res.hit = hit;
         res.way = WAY_W'(way);
         res.hit_count = hits;
         res.access_count = accesses;
         pending_lookups.insert(pending_lookups.size(), res);
      endfunction

      function void check_lookup(bit hit, bit [WAY_W-1:0] way,
                                 bit [COUNT_W-1:0] hc, bit [COUNT_W-1:0] ac);
         lookup_result exp_res;
         if (pending_lookups.size() == 0) begin
            $display("%0t: result with no pending transaction", $time);
            errors++;
            return;
         end
         exp_res = pending_lookups.pop_front();
         if (hit !== exp_res.hit) begin
            $display("%0t: hit expected %0d got %0d", $time, exp_res.hit, hit);
            errors++;
         end
         if (way !== exp_res.way) begin
            $display("%0t: way_used expected %0d got %0d", $time, exp_res.way, way);
            errors++;
         end
         if (hc !== exp_res.hit_count) begin
            $display("%0t: hit_count expected %0d got %0d", $time, exp_res.hit_count, hc);
            errors++;
         end
         if (ac !== exp_res.access_count) begin
            $display("%0t: access_count expected %0d got %0d",
                     $time, exp_res.access_count, ac);
            errors++;
         end
      endfunction

      function int pending();
         return pending_lookups.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [ADDR_W-1:0]     req_address;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_hit;
   logic [WAY_W-1:0]      rsp_way_used;
   logic [COUNT_W-1:0]    rsp_hit_count;
   logic [COUNT_W-1:0]    rsp_access_count;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   lru_tag_predictor cache_model = new;
   bit calm_mode;
   int rsp_hold;

   set_assoc_lru_cache_tags_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_address(req_address),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit),
      .rsp_way_used(rsp_way_used),
      .rsp_hit_count(rsp_hit_count),
      .rsp_access_count(rsp_access_count),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm_mode) rsp_hold = gap_len();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         cache_model.check_lookup(rsp_hit, rsp_way_used, rsp_hit_count, rsp_access_count);
   end

   initial begin
      #TIMEOUT_NS;
      $display("tb_top NOT OK");
      $finish;
   end

   task automatic send_access(logic [ADDR_W-1:0] addr);
      int gap;
      req_valid = 1'b1;
      req_address = addr;
      do @(posedge clock); while (!req_ready);
      cache_model.note_access(addr);
      @(negedge clock);
      gap = calm_mode ? 0 : gap_len();
      if (gap > 0) begin
         req_valid = 1'b0;
         req_address = $urandom();
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (cache_model.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic program_reg(logic [CSR_IDX_W-1:0] idx, bit [CSR_DATA_W-1:0] value);
      bit [CSR_DATA_W-1:0] readback;
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      readback = cache_model.set_reg(idx, value);
      @(negedge clock);
      penable = 1'b0;
      pwrite = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== readback) begin
         $display("%0t: register %0d readback expected %0h got %0h",
                  $time, idx, readback, prdata);
         cache_model.errors++;
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic set_config(int ways, int offset, int index);
      drain();
      repeat (4) @(negedge clock);
      program_reg(CSR_WAYS, CSR_DATA_W'(ways));
      program_reg(CSR_OFFSET, CSR_DATA_W'(offset));
      program_reg(CSR_INDEX, CSR_DATA_W'(index));
   endtask

   // mostly a few hot sets and small tags so hits and evictions happen
   function automatic logic [ADDR_W-1:0] rand_address();
      logic [63:0] a64;
      logic [63:0] tag;
      int off, ib, set_idx;
      if ($urandom_range(0, 99) < 25) return $urandom();
      off = int'(cache_model.offset_cfg);
      ib = cache_model.active_index_bits();
      set_idx = $urandom_range(0, 3) & ((1 << ib) - 1);
      if ($urandom_range(0, 9) == 0) tag = 64'($urandom());
      else tag = 64'($urandom_range(0, cache_model.active_ways() + 2));
      a64 = (tag << (off + ib)) | (64'(set_idx) << off) |
            (64'($urandom()) & ((64'd1 << off) - 64'd1));
      return a64[ADDR_W-1:0];
   endfunction

   int phase_cfg [9][3] = '{
      '{8, 4, 2}, '{1, 0, 0}, '{0, 16, 10}, '{15, 31, 15}, '{4, 2, 3},
      '{8, 0, 10}, '{3, 5, 12}, '{9, 16, 0}, '{2, 8, 1}
   };

   initial begin
      int n_items;
      reset = 1'b1;
      req_valid = 1'b0;
      req_address = '0;
      rsp_ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      calm_mode = 1'b0;
      rsp_hold = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);

      // reset configuration: 1 way, 4 offset bits, 6 index bits
      send_access(32'h0000_0000);
      send_access(32'h0000_0008);
      send_access(32'h0000_0400);
      send_access(32'h0000_0000);
      send_access(32'hFFFF_FFFF);

      // split changes without flush; fill, hit, LRU eviction
      set_config(4, 4, 2);
      send_access(32'h0000_0000);
      send_access(32'h0000_0040);
      send_access(32'h0000_0080);
      send_access(32'h0000_00C0);
      send_access(32'h0000_0100);
      send_access(32'h0000_0080);
      send_access(32'h0000_0000);
      send_access(32'hAAAA_AAAA);
      send_access(32'h5555_5555);

      // shrink ways to zero then regrow: duplicate tag, lowest way hits
      set_config(2, 4, 3);
      send_access(32'h0000_0060);
      send_access(32'h0000_00E0);
      set_config(0, 4, 3);
      send_access(32'h0000_00E0);
      set_config(2, 4, 3);
      send_access(32'h0000_00E0);

      for (int p = 0; p < 9; p++) begin
         set_config(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
         calm_mode = ($urandom_range(0, 3) == 0);
         n_items = 48;
         for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2) drain();
            send_access(rand_address());
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (cache_model.errors == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end
endmodule
